>>> rtl/core/tea_block_cipher_defines.svh
`ifndef TEA_BLOCK_CIPHER_DEFINES_SVH
`define TEA_BLOCK_CIPHER_DEFINES_SVH

// Clocked check, muted while reset is applied.
`define TEA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is applied.
`define TEA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/tea_pkg.sv
`timescale 1ns / 1ps
package tea_pkg;

    localparam int ROUNDS    = 32;
    localparam int NUM_CELLS = 2 * ROUNDS;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = $clog2(NUM_CELLS + 2);

    localparam logic [WORD_W-1:0] DELTA        = 32'h9e37_79b9;
    localparam logic [WORD_W-1:0] DEC_SUM_INIT = WORD_W'(64'(DELTA) * ROUNDS);

    localparam logic [CFG_IDX_W-1:0] KEY_IDX0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] KEY_IDX1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] KEY_IDX2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] KEY_IDX3 = 2'd3;

    typedef enum logic {
        OP_ENC = 1'b0,
        OP_DEC = 1'b1
    } tea_op_t;

    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } tea_key_t;

    // phase: 0 for the first half-round of a round, 1 for the second
    typedef struct packed {
        tea_op_t           op;
        logic              phase;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] s;
    } tea_item_t;

endpackage

>>> rtl/core/tea_ifs.sv
`timescale 1ns / 1ps
interface tea_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] half_first;
    logic [31:0] half_second;

    modport source (output valid, output opcode, output half_first, output half_second,
                    input ready);
    modport sink (input valid, input opcode, input half_first, input half_second,
                  output ready);
endinterface

interface tea_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_first;
    logic [31:0] out_second;

    modport source (output valid, output out_first, output out_second, input ready);
    modport sink (input valid, input out_first, input out_second, output ready);
endinterface

>>> rtl/core/tea_block_cipher.sv
`timescale 1ns / 1ps
// TEA block engine, 32 rounds, 128-bit key.
// Input channel in_ch: one request carries opcode (0 encrypt, 1 decrypt) and the
// two 32-bit halves of a block. Output channel out_ch: one result per request,
// the processed halves out_first and out_second, in request order.
// Key: four 32-bit words written through cfg_we / cfg_index / cfg_data; write
// them only while no request is in flight. A write takes effect at the next edge.
// Structure: a row of 64 half-round cells, each registered; a request passes
// through every cell register before its result can be taken from out_ch.
// Throughput is one request per cycle while out_ch.ready stays high.
// Stall: a one-entry skid register sits behind the last cell. When the receiver
// drops ready the skid catches the leaving result; in_ch.ready then falls on the
// next cycle and the whole row holds until the skid drains. in_ch.ready comes
// from a register only.
// Reset: clears the key words to zero and empties the row and the skid;
// in_ch.ready is high right after reset.
module tea_block_cipher
    import tea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    tea_in_if.sink               in_ch,
    tea_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    tea_key_t          key_reg;
    logic              skid_full_reg;
    logic [WORD_W-1:0] skid_a_reg;
    logic [WORD_W-1:0] skid_b_reg;
    logic              advance;
    logic              stage_valid [NUM_CELLS+1];
    tea_item_t         stage_data  [NUM_CELLS+1];
    logic              last_valid;
    tea_item_t         last_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                KEY_IDX0: key_reg.k0 <= cfg_data;
                KEY_IDX1: key_reg.k1 <= cfg_data;
                KEY_IDX2: key_reg.k2 <= cfg_data;
                KEY_IDX3: key_reg.k3 <= cfg_data;
                default:  key_reg    <= key_reg;
            endcase
        end
    end

    assign advance     = ~skid_full_reg;
    assign in_ch.ready = advance;

    always_comb
    begin
        stage_valid[0]       = in_ch.valid;
        stage_data[0].op     = tea_op_t'(in_ch.opcode);
        stage_data[0].phase  = 1'b0;
        stage_data[0].a      = in_ch.half_first;
        stage_data[0].b      = in_ch.half_second;
        stage_data[0].s      = (tea_op_t'(in_ch.opcode) == OP_DEC) ? DEC_SUM_INIT : DELTA;
    end

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        tea_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .key       (key_reg),
            .in_valid  (stage_valid[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    assign last_valid = stage_valid[NUM_CELLS];
    assign last_data  = stage_data[NUM_CELLS];

    // Catch the leaving result when the receiver stalls; drain on ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (!skid_full_reg && last_valid && !out_ch.ready)
        begin
            skid_full_reg <= 1'b1;
        end
        else if (skid_full_reg && out_ch.ready)
        begin
            skid_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
        begin
            skid_a_reg <= last_data.a;
            skid_b_reg <= last_data.b;
        end
    end

    assign out_ch.valid      = skid_full_reg | last_valid;
    assign out_ch.out_first  = skid_full_reg ? skid_a_reg : last_data.a;
    assign out_ch.out_second = skid_full_reg ? skid_b_reg : last_data.b;

endmodule

>>> rtl/core/tea_cell.sv
`timescale 1ns / 1ps
module tea_cell
    import tea_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  tea_key_t  key,
    input  logic      in_valid,
    input  tea_item_t in_data,
    output logic      out_valid,
    output tea_item_t out_data
);

    logic              valid_reg;
    tea_item_t         data_reg;
    tea_item_t         data_next;
    logic              upd_a;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] ka;
    logic [WORD_W-1:0] kb;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] tgt;
    logic [WORD_W-1:0] res;

    // Encrypt updates a then b; decrypt updates b then a.
    always_comb
    begin
        upd_a = ((in_data.op == OP_DEC) == in_data.phase);
        x     = upd_a ? in_data.b : in_data.a;
        ka    = upd_a ? key.k0 : key.k2;
        kb    = upd_a ? key.k1 : key.k3;
        tgt   = upd_a ? in_data.a : in_data.b;
        mix   = ((x << 4) + ka) ^ (x + in_data.s) ^ ((x >> 5) + kb);
        res   = (in_data.op == OP_DEC) ? (tgt - mix) : (tgt + mix);

        data_next       = in_data;
        data_next.phase = ~in_data.phase;
        if (upd_a)
        begin
            data_next.a = res;
        end
        else
        begin
            data_next.b = res;
        end
        // advance the running sum after the second half-round
        if (in_data.phase)
        begin
            data_next.s = (in_data.op == OP_DEC) ? (in_data.s - DELTA) : (in_data.s + DELTA);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/tea_chk.sv
`timescale 1ns / 1ps
`include "tea_block_cipher_defines.svh"
module tea_chk
    import tea_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [WORD_W-1:0] out_first,
    input logic [WORD_W-1:0] out_second
);

    logic [CNT_W-1:0] pend_reg;
    logic [CNT_W-1:0] pend_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = in_valid & in_ready;
    assign out_acc = out_valid & out_ready;

    // track requests accepted but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `TEA_ASSERT(a_no_spurious_out, out_valid |-> (pend_reg != '0), "result with no request pending")
    `TEA_ASSERT(a_pend_bound, pend_reg <= CNT_W'(NUM_CELLS + 1), "more requests in flight than storage")
    `TEA_ASSERT(a_ready_when_empty, (pend_reg == '0) |-> in_ready, "input blocked while empty")
    `TEA_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_first) && $stable(out_second)), "stalled result changed")

endmodule

bind tea_block_cipher tea_chk u_tea_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_first  (out_ch.out_first),
    .out_second (out_ch.out_second)
);

>>> verif/tea_block_cipher_checker.sv
`timescale 1ns / 1ps
module tea_block_cipher_checker
    import tea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tea_in_if           in_ch,
    tea_out_if          out_ch,
    input  logic        cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output int unsigned pending,
    output int unsigned fail_count
);

    typedef struct packed {
        logic [WORD_W-1:0] first;
        logic [WORD_W-1:0] second;
    } cipher_block_t;

    tea_key_t      cipher_key;
    cipher_block_t expected_blocks[$];

    function automatic logic [WORD_W-1:0] mix_word(logic [WORD_W-1:0] x, logic [WORD_W-1:0] s,
                                                   logic [WORD_W-1:0] ka,
                                                   logic [WORD_W-1:0] kb);
        return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
    endfunction

    function automatic cipher_block_t tea_transform(tea_op_t op, logic [WORD_W-1:0] a_in,
                                                    logic [WORD_W-1:0] b_in, tea_key_t key);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] sum;
        cipher_block_t     blk;
        a = a_in;
        b = b_in;
        if (op == OP_ENC)
        begin
            sum = '0;
            for (int r = 0; r < ROUNDS; r++)
            begin
                sum = sum + DELTA;
                a = a + mix_word(b, sum, key.k0, key.k1);
                b = b + mix_word(a, sum, key.k2, key.k3);
            end
        end
        else
        begin
            // start from the sum left after all rounds, mod 2^32
            sum = WORD_W'(DELTA * ROUNDS);
            for (int r = 0; r < ROUNDS; r++)
            begin
                b = b - mix_word(a, sum, key.k2, key.k3);
                a = a - mix_word(b, sum, key.k0, key.k1);
                sum = sum - DELTA;
            end
        end
        blk.first  = a;
        blk.second = b;
        return blk;
    endfunction

    function automatic void note_error(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : track_key
        if (!rst_n)
            cipher_key <= '0;
        else if (cfg_we)
        begin
            case (cfg_index)
                KEY_IDX0: cipher_key.k0 <= cfg_data;
                KEY_IDX1: cipher_key.k1 <= cfg_data;
                KEY_IDX2: cipher_key.k2 <= cfg_data;
                KEY_IDX3: cipher_key.k3 <= cfg_data;
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin : score_blocks
        cipher_block_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                expected_blocks.push_back(tea_transform(tea_op_t'(in_ch.opcode),
                                                        in_ch.half_first, in_ch.half_second,
                                                        cipher_key));
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_blocks.size() == 0)
                    note_error($sformatf("result %h_%h with no request pending",
                                         out_ch.out_first, out_ch.out_second));
                else
                begin
                    want = expected_blocks.pop_front();
                    if (out_ch.out_first !== want.first)
                        note_error($sformatf("out_first expected %h got %h",
                                             want.first, out_ch.out_first));
                    if (out_ch.out_second !== want.second)
                        note_error($sformatf("out_second expected %h got %h",
                                             want.second, out_ch.out_second));
                end
            end
            pending = expected_blocks.size();
        end
    end

endmodule

>>> verif/tea_block_cipher_test.sv
`timescale 1ns / 1ps
module tea_block_cipher_test;
    import tea_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 80;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;
    int unsigned          pending;
    int unsigned          fail_count;
    int unsigned          quiet_cycles;
    bit                   source_quiet;
    bit                   sink_quiet;

    tea_in_if  in_ch ();
    tea_out_if out_ch ();

    tea_block_cipher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tea_block_cipher_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always #6 clk = ~clk;

    function automatic logic [WORD_W-1:0] edge_word(int unsigned idx);
        case (idx)
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0001;
            5: return 32'h5555_5555;
            6: return 32'hAAAA_AAAA;
            default: return 32'hFFFF_FFFE;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        if ($urandom_range(0, 7) == 0)
            return edge_word($urandom_range(0, 7));
        return $urandom();
    endfunction

    // entered and left at a falling edge
    task automatic send_block(tea_op_t op, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        int unsigned gap;
        gap = source_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.half_first  <= a;
        in_ch.half_second <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic run_key_phase(tea_key_t key, int unsigned count, bit src_q, bit snk_q);
        drain();
        write_reg(KEY_IDX0, key.k0);
        write_reg(KEY_IDX1, key.k1);
        write_reg(KEY_IDX2, key.k2);
        write_reg(KEY_IDX3, key.k3);
        cfg_we <= 1'b0;
        @(negedge clk);
        source_quiet = src_q;
        sink_quiet   = snk_q;
        repeat (count)
            send_block(tea_op_t'($urandom_range(0, 1)), pick_word(), pick_word());
    endtask

    initial
    begin : result_sink
        int unsigned stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = sink_quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // hold the count at zero while traffic moves
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.opcode      = OP_ENC;
        in_ch.half_first  = '0;
        in_ch.half_second = '0;
        cfg_we            = 1'b0;
        cfg_index         = KEY_IDX0;
        cfg_data          = '0;
        source_quiet      = 1'b0;
        sink_quiet        = 1'b0;
        quiet_cycles      = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // edge values under the reset key, both directions
        for (int i = 0; i < 8; i++)
        begin
            send_block(OP_ENC, edge_word(i), edge_word(7 - i));
            send_block(OP_DEC, edge_word(i), edge_word(i));
        end

        run_key_phase('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                      200, 1'b1, 1'b1);
        run_key_phase('{$urandom(), $urandom(), $urandom(), $urandom()}, 400, 1'b0, 1'b0);
        run_key_phase('{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
                      200, 1'b0, 1'b0);
        run_key_phase('{$urandom(), $urandom(), $urandom(), $urandom()}, 300, 1'b1, 1'b0);
        run_key_phase('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
                      200, 1'b0, 1'b1);

        drain();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/tea_pkg.sv
rtl/core/tea_ifs.sv
rtl/core/tea_cell.sv
rtl/core/tea_block_cipher.sv
rtl/core/tea_chk.sv
verif/tea_block_cipher_checker.sv
verif/tea_block_cipher_test.sv
